>>> rtl/assert_macros.svh
// Assertion macros shared by the order book RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> rtl/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
// No dependencies.
`timescale 1ns / 1ps
package lobm_pkg;
    localparam int ORDERS = 32;
    localparam int SLOT_W = $clog2(ORDERS);
    localparam int CNT_W = $clog2(ORDERS + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [63:0] id;
        logic [63:0] stamp;
        logic [31:0] arrival;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_SCAN_RD, S_SCAN_CHK, S_FILL_RD,
        S_FILL, S_TRADE, S_REST, S_STATUS
    } state_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        entry_t            wdata;
        logic [SLOT_W-1:0] raddr;
    } mem_req_t;
endpackage

>>> rtl/lobm_ram.sv
// Order entry memory: one write port, one registered read port.
// Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_ram
(
    input  logic                clk,
    input  lobm_pkg::mem_req_t  req,
    output lobm_pkg::entry_t    rdata
);
    lobm_pkg::entry_t mem [lobm_pkg::ORDERS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

>>> rtl/limit_order_book_matcher.sv
// Limit order book, price-time priority, ORDERS slots in one synchronous memory.
// Flow: an add scans all slots, reading then checking each one per pass; each fill
// starts a new pass; rest writes a free slot if any, then status loads the result;
// cancel/modify lookup reads slots in order up to the match. A busy output holds a fill or status in place.
// Throughput: one command in flight; the next is accepted after its status loads.
// Reset (rst_n, async low) clears valid bits, arrival counter and control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module limit_order_book_matcher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [63:0] ord_id,
    input  logic        side,
    input  logic signed [31:0] limit_price,
    input  logic [31:0] quantity,
    input  logic [63:0] stamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [63:0] buyer_id,
    output logic [63:0] seller_id,
    output logic signed [31:0] trade_price,
    output logic [31:0] trade_quantity,
    output logic [63:0] trade_stamp,
    output logic [1:0]  status,
    output logic        last
);
    localparam int SW = lobm_pkg::SLOT_W;
    localparam int CW = lobm_pkg::CNT_W;
    localparam logic [CW-1:0] NSLOT = CW'(lobm_pkg::ORDERS);

    lobm_pkg::state_t state_reg, state_next;
    logic [lobm_pkg::ORDERS-1:0] valid_reg, valid_next;
    logic [31:0] arr_reg, arr_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [63:0] id_reg, id_next, stamp_reg, stamp_next;
    logic side_reg, side_next;
    logic [31:0] price_reg, price_next, qty_reg, qty_next;
    logic [CW-1:0] idx_reg, idx_next, nfill_reg, nfill_next;
    logic [SW-1:0] best_reg, best_next;
    logic found_reg, found_next;
    logic [31:0] bprice_reg, bprice_next, bage_reg, bage_next;
    logic [1:0] st_reg, st_next;
    logic ov_reg, ov_next;
    logic okind_reg, okind_next, olast_reg, olast_next;
    logic [63:0] obuy_reg, obuy_next, osell_reg, osell_next, ostamp_reg, ostamp_next;
    logic [31:0] oprice_reg, oprice_next, oqty_reg, oqty_next;
    logic [1:0] ost_reg, ost_next;

    lobm_pkg::mem_req_t req;
    lobm_pkg::entry_t rd;
    logic [SW-1:0] idx_s;
    logic [31:0] age, fill;
    logic better, eligible;
    logic free_any;
    logic [SW-1:0] free_slot;

    lobm_ram u_ram (.clk(clk), .req(req), .rdata(rd));

    assign idx_s = idx_reg[SW-1:0];
    assign age = arr_reg - rd.arrival;
    assign fill = (qty_reg < rd.quantity) ? qty_reg : rd.quantity;

    always_comb
    begin
        free_any = 1'b0;
        free_slot = '0;
        for (int i = lobm_pkg::ORDERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    always_comb
    begin
        eligible = valid_reg[idx_s] && (rd.side != side_reg) &&
            (side_reg ? ($signed(rd.price) >= $signed(price_reg))
                      : ($signed(rd.price) <= $signed(price_reg)));
        better = !found_reg ||
            (side_reg ? ($signed(rd.price) > $signed(bprice_reg))
                      : ($signed(rd.price) < $signed(bprice_reg))) ||
            ((rd.price == bprice_reg) && (age > bage_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lobm_pkg::S_IDLE;
            valid_reg <= '0;
            arr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            arr_reg <= arr_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; id_reg <= id_next; stamp_reg <= stamp_next;
        side_reg <= side_next; price_reg <= price_next; qty_reg <= qty_next;
        idx_reg <= idx_next; nfill_reg <= nfill_next; best_reg <= best_next;
        found_reg <= found_next; bprice_reg <= bprice_next; bage_reg <= bage_next;
        st_reg <= st_next; okind_reg <= okind_next; olast_reg <= olast_next;
        obuy_reg <= obuy_next; osell_reg <= osell_next; ostamp_reg <= ostamp_next;
        oprice_reg <= oprice_next; oqty_reg <= oqty_next; ost_reg <= ost_next;
    end

    always_comb
    begin
        state_next = state_reg; valid_next = valid_reg; arr_next = arr_reg;
        cmd_next = cmd_reg; id_next = id_reg; stamp_next = stamp_reg;
        side_next = side_reg; price_next = price_reg; qty_next = qty_reg;
        idx_next = idx_reg; nfill_next = nfill_reg; best_next = best_reg;
        found_next = found_reg; bprice_next = bprice_reg; bage_next = bage_reg;
        st_next = st_reg; ov_next = ov_reg; okind_next = okind_reg;
        olast_next = olast_reg; obuy_next = obuy_reg; osell_next = osell_reg;
        ostamp_next = ostamp_reg; oprice_next = oprice_reg; oqty_next = oqty_reg;
        ost_next = ost_reg;
        req = '0;
        req.raddr = idx_s;
        in_ready = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            lobm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = cmd; id_next = ord_id; stamp_next = stamp;
                    side_next = side; price_next = limit_price; qty_next = quantity;
                    idx_next = '0; nfill_next = '0; found_next = 1'b0;
                    st_next = lobm_pkg::ST_OK;
                    if (cmd == lobm_pkg::CMD_ADD)
                    begin
                        state_next = lobm_pkg::S_SCAN_RD;
                    end
                    else if (cmd == lobm_pkg::CMD_CANCEL || cmd == lobm_pkg::CMD_MODIFY)
                    begin
                        state_next = lobm_pkg::S_FIND_RD;
                    end
                    else
                    begin
                        state_next = lobm_pkg::S_STATUS;
                    end
                end
            end
            lobm_pkg::S_FIND_RD:
            begin
                state_next = lobm_pkg::S_FIND_CHK;
            end
            lobm_pkg::S_FIND_CHK:
            begin
                if (valid_reg[idx_s] && rd.id == id_reg)
                begin
                    valid_next[idx_s] = 1'b0;
                    idx_next = '0;
                    if (cmd_reg == lobm_pkg::CMD_MODIFY)
                    begin
                        side_next = rd.side; price_next = rd.price; stamp_next = rd.stamp;
                        state_next = lobm_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = lobm_pkg::S_STATUS;
                    end
                end
                else if (idx_reg == NSLOT - 1'b1)
                begin
                    st_next = lobm_pkg::ST_NOTFOUND;
                    state_next = lobm_pkg::S_STATUS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = lobm_pkg::S_FIND_RD;
                end
            end
            lobm_pkg::S_SCAN_RD:
            begin
                if (qty_reg == '0)
                begin
                    state_next = lobm_pkg::S_STATUS;
                end
                else if (nfill_reg == NSLOT)
                begin
                    state_next = lobm_pkg::S_REST;
                end
                else
                begin
                    state_next = lobm_pkg::S_SCAN_CHK;
                end
            end
            lobm_pkg::S_SCAN_CHK:
            begin
                if (eligible && better)
                begin
                    found_next = 1'b1; best_next = idx_s;
                    bprice_next = rd.price; bage_next = age;
                end
                if (idx_reg == NSLOT - 1'b1)
                begin
                    idx_next = '0;
                    state_next = (eligible || found_reg) ? lobm_pkg::S_FILL_RD
                                                         : lobm_pkg::S_REST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = lobm_pkg::S_SCAN_RD;
                end
            end
            lobm_pkg::S_FILL_RD:
            begin
                req.raddr = best_reg;
                state_next = lobm_pkg::S_FILL;
            end
            lobm_pkg::S_FILL:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1; okind_next = lobm_pkg::KIND_TRADE; olast_next = 1'b0;
                    ost_next = lobm_pkg::ST_OK;
                    obuy_next = side_reg ? rd.id : id_reg;
                    osell_next = side_reg ? id_reg : rd.id;
                    oprice_next = rd.price; oqty_next = fill; ostamp_next = stamp_reg;
                    qty_next = qty_reg - fill;
                    req.we = 1'b1; req.waddr = best_reg; req.wdata = rd;
                    req.wdata.quantity = rd.quantity - fill;
                    if (rd.quantity == fill)
                    begin
                        valid_next[best_reg] = 1'b0;
                    end
                    nfill_next = nfill_reg + 1'b1;
                    found_next = 1'b0; idx_next = '0;
                    state_next = lobm_pkg::S_SCAN_RD;
                end
                else
                begin
                    req.raddr = best_reg;
                    state_next = lobm_pkg::S_FILL_RD;
                end
            end
            lobm_pkg::S_REST:
            begin
                if (!free_any)
                begin
                    st_next = lobm_pkg::ST_FULL;
                end
                else
                begin
                    valid_next[free_slot] = 1'b1;
                    req.we = 1'b1; req.waddr = free_slot;
                    req.wdata.side = side_reg; req.wdata.price = price_reg;
                    req.wdata.quantity = qty_reg; req.wdata.id = id_reg;
                    req.wdata.stamp = stamp_reg; req.wdata.arrival = arr_reg;
                    arr_next = arr_reg + 1'b1;
                end
                state_next = lobm_pkg::S_STATUS;
            end
            lobm_pkg::S_STATUS:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1; okind_next = lobm_pkg::KIND_STATUS; olast_next = 1'b1;
                    ost_next = st_reg; obuy_next = '0; osell_next = '0;
                    oprice_next = '0; oqty_next = '0; ostamp_next = '0;
                    state_next = lobm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lobm_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign kind = okind_reg;
    assign buyer_id = obuy_reg;
    assign seller_id = osell_reg;
    assign trade_price = oprice_reg;
    assign trade_quantity = oqty_reg;
    assign trade_stamp = ostamp_reg;
    assign status = ost_reg;
    assign last = olast_reg;

    `ASSERT_NEVER(a_ready_busy, clk, rst_n,
        in_ready && (state_reg != lobm_pkg::S_IDLE), "ready outside idle")
    `ASSERT_NEVER(a_trade_zero, clk, rst_n,
        out_valid && !kind && (trade_quantity == '0), "zero trade quantity")
    `ASSERT_CLK(a_last_status, clk, rst_n, out_valid |-> (last == kind),
        "last must mark status beat")
endmodule

>>> tb/tb_limit_order_book_matcher.sv
// Testbench for the limit order book matcher: drives add, cancel, modify and nop
// commands and checks every trade and status beat against an internal book model.
// Depends on lobm_pkg and the limit_order_book_matcher RTL.
`timescale 1ns / 1ps
module tb_limit_order_book_matcher;
    typedef struct packed {
        logic        kind;
        logic [63:0] buyer_id;
        logic [63:0] seller_id;
        logic [31:0] trade_price;
        logic [31:0] trade_quantity;
        logic [63:0] trade_stamp;
        logic [1:0]  status;
        logic        last;
    } fill_rec_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [63:0] ord_id;
    logic        side;
    logic signed [31:0] limit_price;
    logic [31:0] quantity;
    logic [63:0] stamp;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [63:0] buyer_id;
    logic [63:0] seller_id;
    logic signed [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic [63:0] trade_stamp;
    logic [1:0]  status;
    logic        last;

    // book model
    logic        bk_valid [lobm_pkg::ORDERS];
    logic        bk_side [lobm_pkg::ORDERS];
    logic [31:0] bk_price [lobm_pkg::ORDERS];
    logic [31:0] bk_qty [lobm_pkg::ORDERS];
    logic [63:0] bk_id [lobm_pkg::ORDERS];
    logic [63:0] bk_stamp [lobm_pkg::ORDERS];
    logic [31:0] bk_arrival [lobm_pkg::ORDERS];
    logic [31:0] arrival_cnt;

    fill_rec_t   expected_fills [$];
    int          errors;
    int          cmds_sent;
    int          beats_checked;
    bit          calm;
    logic [63:0] next_id;

    limit_order_book_matcher i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .ord_id(ord_id), .side(side), .limit_price(limit_price),
        .quantity(quantity), .stamp(stamp), .out_valid(out_valid),
        .out_ready(out_ready), .kind(kind), .buyer_id(buyer_id),
        .seller_id(seller_id), .trade_price(trade_price),
        .trade_quantity(trade_quantity), .trade_stamp(trade_stamp),
        .status(status), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("limit_order_book_matcher test failed");
        $finish;
    end

    function automatic void push_fill(logic k, logic [63:0] b, logic [63:0] s,
                                      logic [31:0] p, logic [31:0] q, logic [63:0] t,
                                      logic [1:0] st, logic l);
        fill_rec_t r;
        r = '{k, b, s, p, q, t, st, l};
        expected_fills.insert(expected_fills.size(), r);
    endfunction

    function automatic logic [1:0] match_and_rest(logic [63:0] id, logic sd,
                                                  logic [31:0] px, logic [31:0] qin,
                                                  logic [63:0] ts);
        int          n;
        int          best;
        int          slot;
        logic signed [31:0] lim;
        logic signed [31:0] p;
        logic signed [31:0] bp;
        logic [31:0] age;
        logic [31:0] bage;
        logic [31:0] q;
        logic [31:0] fill;
        n = 0;
        q = qin;
        lim = px;
        bp = 0;
        bage = 0;
        while (q != 0 && n < lobm_pkg::ORDERS)
        begin
            best = -1;
            for (int i = 0; i < lobm_pkg::ORDERS; i++)
            begin
                if (bk_valid[i] && bk_side[i] != sd)
                begin
                    p = bk_price[i];
                    if (sd == 1'b0 ? (p <= lim) : (p >= lim))
                    begin
                        age = arrival_cnt - bk_arrival[i];
                        if (best < 0 || (sd == 1'b0 ? (p < bp) : (p > bp))
                            || (p == bp && age > bage))
                        begin
                            best = i;
                            bp = p;
                            bage = age;
                        end
                    end
                end
            end
            if (best < 0)
                break;
            fill = (q < bk_qty[best]) ? q : bk_qty[best];
            if (sd == 1'b0)
                push_fill(lobm_pkg::KIND_TRADE, id, bk_id[best], bk_price[best], fill, ts,
                          lobm_pkg::ST_OK, 1'b0);
            else
                push_fill(lobm_pkg::KIND_TRADE, bk_id[best], id, bk_price[best], fill, ts,
                          lobm_pkg::ST_OK, 1'b0);
            n++;
            q -= fill;
            bk_qty[best] -= fill;
            if (bk_qty[best] == 0)
                bk_valid[best] = 1'b0;
        end
        if (q == 0)
            return lobm_pkg::ST_OK;
        slot = -1;
        for (int i = 0; i < lobm_pkg::ORDERS; i++)
        begin
            if (!bk_valid[i] && slot < 0)
                slot = i;
        end
        if (slot < 0)
            return lobm_pkg::ST_FULL;
        bk_valid[slot] = 1'b1;
        bk_side[slot] = sd;
        bk_price[slot] = px;
        bk_qty[slot] = q;
        bk_id[slot] = id;
        bk_stamp[slot] = ts;
        bk_arrival[slot] = arrival_cnt;
        arrival_cnt++;
        return lobm_pkg::ST_OK;
    endfunction

    function automatic void predict_command(logic [1:0] c, logic [63:0] id, logic sd,
                                            logic [31:0] px, logic [31:0] q,
                                            logic [63:0] ts);
        logic [1:0] st;
        int         s;
        st = lobm_pkg::ST_OK;
        if (c == lobm_pkg::CMD_ADD)
            st = match_and_rest(id, sd, px, q, ts);
        else if (c == lobm_pkg::CMD_CANCEL || c == lobm_pkg::CMD_MODIFY)
        begin
            s = -1;
            for (int i = lobm_pkg::ORDERS - 1; i >= 0; i--)
            begin
                if (bk_valid[i] && bk_id[i] == id)
                    s = i;
            end
            if (s < 0)
                st = lobm_pkg::ST_NOTFOUND;
            else
            begin
                bk_valid[s] = 1'b0;
                if (c == lobm_pkg::CMD_MODIFY)
                    st = match_and_rest(id, bk_side[s], bk_price[s], q, bk_stamp[s]);
            end
        end
        push_fill(lobm_pkg::KIND_STATUS, '0, '0, '0, '0, '0, st, 1'b1);
    endfunction

    function automatic int resting_count();
        int n;
        n = 0;
        foreach (bk_valid[i])
            n += bk_valid[i];
        return n;
    endfunction

    function automatic logic [63:0] rest_id_pick();
        int k;
        k = $urandom_range(0, lobm_pkg::ORDERS - 1);
        for (int i = 0; i < lobm_pkg::ORDERS; i++)
        begin
            if (bk_valid[(k + i) % lobm_pkg::ORDERS])
                return bk_id[(k + i) % lobm_pkg::ORDERS];
        end
        return {$urandom, $urandom};
    endfunction

    // valid stays high after a beat so the next command follows back to back unless a random gap drops it
    task automatic send_command(logic [1:0] c, logic [63:0] id, logic sd,
                                logic [31:0] px, logic [31:0] q, logic [63:0] ts);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        ord_id <= id;
        side <= sd;
        limit_price <= px;
        quantity <= q;
        stamp <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_command(c, id, sd, px, q, ts);
        cmds_sent++;
    endtask

    task automatic drain_book();
        in_valid <= 1'b0;
        while (expected_fills.size() != 0)
            @(posedge clk);
        repeat (4 * lobm_pkg::ORDERS) @(posedge clk);
    endtask

    task automatic enter_order(logic sd, logic [31:0] px, logic [31:0] q);
        send_command(lobm_pkg::CMD_ADD, next_id, sd, px, q, {$urandom, $urandom});
        next_id++;
    endtask

    task automatic test_extremes();
        send_command(lobm_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(lobm_pkg::CMD_ADD, 64'd0, 1'b0, 32'h8000_0000, 32'd5, 64'd0);
        send_command(lobm_pkg::CMD_ADD, 64'd7, 1'b0, 32'h7FFF_FFFF, 32'd3, 64'h1234);
        send_command(lobm_pkg::CMD_ADD, 64'd8, 1'b1, 32'h8000_0000, 32'd9, 64'h5678);
        send_command(lobm_pkg::CMD_ADD, 64'd9, 1'b0, 32'd10, 32'd0, 64'd1);
        send_command(lobm_pkg::CMD_CANCEL, 64'hDEAD_BEEF, 1'b0, '0, '0, '0);
        send_command(lobm_pkg::CMD_MODIFY, 64'hDEAD_BEEF, 1'b0, '0, 32'd4, '0);
        send_command(lobm_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 32'd2, '0);
        send_command(lobm_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 32'd0, '0);
        send_command(lobm_pkg::CMD_CANCEL, 64'd0, 1'b0, '0, '0, '0);
        send_command(lobm_pkg::CMD_NOP, 64'd1, 1'b1, 32'd1, 32'd1, 64'd1);
    endtask

    task automatic test_time_priority();
        enter_order(1'b1, 32'd100, 32'd4);
        enter_order(1'b1, 32'd100, 32'd4);
        enter_order(1'b1, 32'd99, 32'd2);
        enter_order(1'b1, 32'hFFFF_FFF0, 32'd1);
        enter_order(1'b0, 32'd100, 32'd7);
        enter_order(1'b0, 32'd100, 32'd20);
        enter_order(1'b1, 32'd50, 32'd30);
    endtask

    task automatic test_book_full();
        drain_book();
        for (int i = 0; i < lobm_pkg::ORDERS + 2; i++)
            enter_order(1'b0, 32'd10 + 32'(i % 3), 32'd1 + 32'(i));
        drain_book();
        enter_order(1'b1, 32'd0, 32'd1000);
        for (int i = 0; i < lobm_pkg::ORDERS + 2; i++)
            enter_order(1'b0, 32'h8000_0000, 32'd1);
        enter_order(1'b1, 32'd5, 32'd2);
        for (int i = 0; i < lobm_pkg::ORDERS / 4; i++)
            send_command(lobm_pkg::CMD_CANCEL, rest_id_pick(), 1'b0, '0, '0, '0);
        drain_book();
    endtask

    task automatic test_random(int count);
        int          r;
        logic [31:0] px;
        logic [31:0] q;
        for (int i = 0; i < count; i++)
        begin
            if (i > count * 3 / 4)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            px = 32'(int'($urandom_range(0, 12)) - 6);
            q = $urandom_range(1, 20);
            if (r < 5)
                px = $urandom;
            if (r < 3)
                q = $urandom;
            if (r < 55 && resting_count() < lobm_pkg::ORDERS - 2)
                enter_order(1'($urandom_range(0, 1)), px, q);
            else if (r < 70)
                send_command(lobm_pkg::CMD_CANCEL, rest_id_pick(),
                             1'($urandom_range(0, 1)), $urandom, $urandom,
                             {$urandom, $urandom});
            else if (r < 85)
                send_command(lobm_pkg::CMD_MODIFY, rest_id_pick(),
                             1'($urandom_range(0, 1)), $urandom,
                             $urandom_range(0, 30), {$urandom, $urandom});
            else if (r < 92)
                send_command(lobm_pkg::CMD_CANCEL, {$urandom, $urandom}, 1'b0, '0, '0, '0);
            else
                enter_order(1'($urandom_range(0, 1)), px, q);
            if (i == count / 2)
                drain_book();
        end
    endtask

    always @(posedge clk)
    begin
        fill_rec_t e;
        fill_rec_t a;
        if (rst_n && out_valid && out_ready)
        begin
            a = '{kind, buyer_id, seller_id, trade_price, trade_quantity, trade_stamp,
                  status, last};
            beats_checked++;
            if (expected_fills.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat expected none actual %h", $time, a);
            end
            else
            begin
                e = expected_fills.pop_front();
                if (e !== a)
                begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, e, a);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || calm)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 4) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        int waited;
        errors = 0;
        cmds_sent = 0;
        beats_checked = 0;
        calm = 1'b0;
        next_id = 64'd1000;
        arrival_cnt = '0;
        foreach (bk_valid[i])
            bk_valid[i] = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = lobm_pkg::CMD_ADD;
        ord_id = '0;
        side = 1'b0;
        limit_price = '0;
        quantity = '0;
        stamp = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_time_priority();
        test_book_full();
        test_random(55);
        in_valid <= 1'b0;
        waited = 0;
        while (expected_fills.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4 * lobm_pkg::ORDERS) @(posedge clk);
        if (expected_fills.size() != 0)
        begin
            errors++;
            $display("%0t: missing beats expected %0d more actual none", $time,
                     expected_fills.size());
        end
        $display("Covered %0d commands and %0d result beats: edge prices, full book,",
                 cmds_sent, beats_checked);
        $display("unknown ids, zero quantity, modify and random matching traffic.");
        if (errors == 0)
            $display("limit_order_book_matcher test passed");
        else
            $display("limit_order_book_matcher test failed");
        $finish;
    end
endmodule
